FILE: src/pbrt_pkg.sv
// ----------------------------------------------------------------------------
// pbrt_pkg: shared types and constants of the piece block request tracker
// Holds table dimensions, the block entry layout, operation and status codes,
// and the result bundle passed from the sequencer to the top level.
// ----------------------------------------------------------------------------
package pbrt_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int OFF_W      = 24;
   localparam int LEN_W      = 25;
   localparam int POS_W      = 26;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int SIZE_W     = 25;

   typedef enum logic [2:0] {
      OP_REQUEST  = 3'd0,
      OP_LOOKUP   = 3'd1,
      OP_REMOVE   = 3'd2,
      OP_MARK     = 3'd3,
      OP_ASSIGN   = 3'd4,
      OP_CHECK    = 3'd5,
      OP_VERDICT  = 3'd6,
      OP_UNUSED   = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      ST_NEW       = 3'd0,
      ST_EXISTING  = 3'd1,
      ST_NOTHING   = 3'd2,
      ST_FULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef struct packed {
      logic [OFF_W-1:0] start;
      logic [LEN_W-1:0] len;
      logic             done;
      logic             assigned;
   } entry_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] index;
      logic [OFF_W-1:0] begin_off;
      logic [LEN_W-1:0] length;
      logic             complete;
      logic             piece_done;
   } result_type;

endpackage

FILE: src/pbrt_cell.sv
// ----------------------------------------------------------------------------
// pbrt_cell: one table slot of the rotating block chain
// Takes the entry of its neighbor whenever the chain shifts.
// ----------------------------------------------------------------------------
module pbrt_cell import pbrt_pkg::*; (
   input  logic      clock,
   input  logic      shift,
   input  entry_type entry_in,
   output entry_type entry_out
);

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

FILE: src/pbrt_ctrl.sv
// ----------------------------------------------------------------------------
// pbrt_ctrl: sequencer of the piece block request tracker
// Walks the rotating chain one entry per cycle, decides the operation and
// rewrites the stream that re-enters the chain tail.
// ----------------------------------------------------------------------------
module pbrt_ctrl import pbrt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  opcode_type        opcode,
   input  logic [LEN_W-1:0]  block_length,
   input  logic [OFF_W-1:0]  block_offset,
   input  logic [IDX_W-1:0]  entry_index,
   input  logic              flag_value,
   input  logic [SIZE_W-1:0] eff_size,
   input  entry_type         head,
   input  entry_type         head_next,
   input  logic              slot_free,
   output logic              ready,
   output logic              shift,
   output entry_type         tail,
   output logic              res_load,
   output result_type        res
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              verified_ff, verified_in;
   opcode_type        op_ff, op_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              flag_ff, flag_in;
   logic              idx_ok_ff, idx_ok_in;
   logic              decided_ff, decided_in;
   logic [POS_W-1:0]  tmp_ff, tmp_in;
   logic              ins_ff, ins_in;
   entry_type         carry_ff, carry_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              cmp_ok_ff, cmp_ok_in;
   status_type        st_ff, st_in;
   logic [IDX_W-1:0]  ridx_ff, ridx_in;
   logic [OFF_W-1:0]  rbeg_ff, rbeg_in;
   logic [LEN_W-1:0]  rlen_ff, rlen_in;

   logic              in_tab, in_new, last, do_make, comp_scan, complete_old;
   logic [POS_W-1:0]  gap, nlen, eff_ext;
   entry_type         out_e;

   assign eff_ext = POS_W'(eff_size);
   assign ready   = (state_ff == S_IDLE);
   assign shift   = (state_ff == S_SCAN);
   assign tail    = out_e;

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      count_in    = count_ff;
      verified_in = verified_ff;
      op_in       = op_ff;
      len_in      = len_ff;
      off_in      = off_ff;
      idx_in      = idx_ff;
      flag_in     = flag_ff;
      idx_ok_in   = idx_ok_ff;
      decided_in  = decided_ff;
      tmp_in      = tmp_ff;
      ins_in      = ins_ff;
      carry_in    = carry_ff;
      pos_in      = pos_ff;
      cmp_ok_in   = cmp_ok_ff;
      st_in       = st_ff;
      ridx_in     = ridx_ff;
      rbeg_in     = rbeg_ff;
      rlen_in     = rlen_ff;
      out_e       = head;
      do_make     = 1'b0;
      gap         = '0;
      nlen        = '0;
      res_load    = 1'b0;
      in_new      = 1'b0;
      in_tab      = {1'b0, step_ff} < count_ff;
      last        = (step_ff == IDX_W'(MAX_BLOCKS - 1));
      comp_scan   = cmp_ok_ff && (pos_ff == eff_ext);
      complete_old = verified_ff || comp_scan;

      res.status     = st_ff;
      res.index      = ridx_ff;
      res.begin_off  = rbeg_ff;
      res.length     = rlen_ff;
      res.complete   = complete_old;
      res.piece_done = verified_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = opcode;
               len_in     = block_length;
               off_in     = block_offset;
               idx_in     = entry_index;
               flag_in    = flag_value;
               idx_ok_in  = {1'b0, entry_index} < count_ff;
               step_in    = '0;
               decided_in = 1'b0;
               tmp_in     = '0;
               ins_in     = 1'b0;
               pos_in     = '0;
               cmp_ok_in  = 1'b1;
               ridx_in    = '0;
               rbeg_in    = '0;
               rlen_in    = '0;
               unique case (opcode)
                  OP_LOOKUP: st_in = ST_NOT_FOUND;
                  OP_REMOVE, OP_MARK, OP_ASSIGN: begin
                     st_in = idx_ok_in ? ST_EXISTING : ST_NOT_FOUND;
                  end
                  OP_CHECK: st_in = ST_EXISTING;
                  default: st_in = ST_NOTHING;
               endcase
               // A removal shrinks the table right away; the rotation closes the hole.
               if (opcode == OP_REMOVE && idx_ok_in) begin
                  count_in = count_ff - 1'b1;
               end
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            step_in = step_ff + 1'b1;
            // After an insertion every entry moves one slot further down.
            if (ins_ff) begin
               out_e    = carry_ff;
               carry_in = head;
            end
            if (op_ff == OP_REQUEST && !verified_ff && !decided_ff) begin
               if (in_tab) begin
                  if (!head.done && !head.assigned) begin
                     decided_in = 1'b1;
                     st_in      = ST_EXISTING;
                     ridx_in    = step_ff;
                     rbeg_in    = head.start;
                     rlen_in    = head.len;
                  end else if (tmp_ff < POS_W'(head.start)) begin
                     decided_in = 1'b1;
                     do_make    = 1'b1;
                     gap        = POS_W'(head.start) - tmp_ff;
                  end else begin
                     tmp_in = POS_W'(head.start) + POS_W'(head.len);
                  end
               end else begin
                  decided_in = 1'b1;
                  if (tmp_ff < eff_ext) begin
                     do_make = 1'b1;
                     gap     = eff_ext - tmp_ff;
                  end
               end
               nlen = (gap < POS_W'(len_ff)) ? gap : POS_W'(len_ff);
               if (do_make && len_ff != '0) begin
                  if (count_ff == CNT_W'(MAX_BLOCKS)) begin
                     st_in = ST_FULL;
                  end else begin
                     out_e.start    = tmp_ff[OFF_W-1:0];
                     out_e.len      = nlen[LEN_W-1:0];
                     out_e.done     = 1'b0;
                     out_e.assigned = 1'b0;
                     carry_in       = head;
                     ins_in         = 1'b1;
                     count_in       = count_ff + 1'b1;
                     st_in          = ST_NEW;
                     ridx_in        = step_ff;
                     rbeg_in        = tmp_ff[OFF_W-1:0];
                     rlen_in        = nlen[LEN_W-1:0];
                  end
               end
            end
            if (op_ff == OP_LOOKUP && in_tab && !decided_ff &&
                head.start == off_ff && head.len == len_ff) begin
               decided_in = 1'b1;
               st_in      = ST_EXISTING;
               ridx_in    = step_ff;
               rbeg_in    = head.start;
               rlen_in    = head.len;
            end
            if ((op_ff == OP_REMOVE || op_ff == OP_MARK || op_ff == OP_ASSIGN) &&
                idx_ok_ff && step_ff == idx_ff) begin
               ridx_in = step_ff;
               rbeg_in = head.start;
               rlen_in = head.len;
               if (op_ff == OP_MARK) begin
                  out_e.done = 1'b1;
               end else if (op_ff == OP_ASSIGN) begin
                  out_e.assigned = flag_ff;
               end
            end
            if (op_ff == OP_REMOVE && idx_ok_ff && step_ff >= idx_ff) begin
               out_e = head_next;
            end
            // Contiguity is tracked on the rewritten stream, so it reflects the new table.
            in_new = {1'b0, step_ff} < count_in;
            if (in_new && cmp_ok_ff) begin
               if (POS_W'(out_e.start) == pos_ff && out_e.done) begin
                  pos_in = pos_ff + POS_W'(out_e.len);
               end else begin
                  cmp_ok_in = 1'b0;
               end
            end
            if (last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (op_ff == OP_REQUEST && !verified_ff && !decided_ff) begin
               res.status = (tmp_ff < eff_ext && len_ff != '0) ? ST_FULL : ST_NOTHING;
            end
            if (op_ff == OP_VERDICT) begin
               if (complete_old) begin
                  res.status     = ST_EXISTING;
                  res.complete   = flag_ff || (eff_size == '0);
                  res.piece_done = flag_ff;
               end else begin
                  res.status = ST_NOTHING;
               end
            end
            if (slot_free) begin
               res_load = 1'b1;
               state_in = S_IDLE;
               if (op_ff == OP_VERDICT && complete_old) begin
                  verified_in = flag_ff;
                  count_in    = '0;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         verified_ff <= 1'b0;
         ins_ff      <= 1'b0;
         decided_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         verified_ff <= verified_in;
         ins_ff      <= ins_in;
         decided_ff  <= decided_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      op_ff     <= op_in;
      len_ff    <= len_in;
      off_ff    <= off_in;
      idx_ff    <= idx_in;
      flag_ff   <= flag_in;
      idx_ok_ff <= idx_ok_in;
      tmp_ff    <= tmp_in;
      carry_ff  <= carry_in;
      pos_ff    <= pos_in;
      cmp_ok_ff <= cmp_ok_in;
      st_ff     <= st_in;
      ridx_ff   <= ridx_in;
      rbeg_ff   <= rbeg_in;
      rlen_ff   <= rlen_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count above table depth");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && last) |=> state_ff == S_DONE)
      else $error("scan did not end after a full rotation");

   a_insert_only_request: assert property (@(posedge clock) disable iff (reset)
      ins_ff |-> op_ff == OP_REQUEST)
      else $error("insert carry active outside a request");

   a_idle_no_shift: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SCAN) |-> !shift)
      else $error("chain shifted outside a scan");

endmodule

FILE: src/piece_block_request_tracker.sv
// ----------------------------------------------------------------------------
// piece_block_request_tracker: block table of one piece
// Keeps the sorted list of byte ranges of a piece in a rotating chain of cells
// and serves request, lookup, remove, mark, assign, check and verdict commands.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------------
//  req     | in        | req_tvalid/req_tready | tuser opcode, tdata operands
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser status, tdata result
//  csr     | in/out    | APB, pready always 1  | piece_size at byte address 0
//
// A request is accepted, then the table, which lives in a ring of
// MAX_BLOCKS cells, rotates once while the sequencer inspects
// and rewrites one entry per cycle at the head of the ring; then the
// result is handed to the output register once that register is free.
// Reset is synchronous and active high; it empties the table, clears the
// piece-done flag and sets piece_size to 262144. Entry contents are not reset.
// A new request is accepted while a previous result still waits in the output
// register; a request finishes its rotation and then waits until that register
// is free, so a stalled result channel halts the input after one request.
//
module piece_block_request_tracker import pbrt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: block_length[24:0], block_offset[48:25], entry_index[54:49],
   //            flag_value[55]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [55:0]           req_tdata,
   // req_tuser: opcode[2:0]
   input  logic [2:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rsp_tdata: result_index[5:0], result_begin[29:6], result_length[54:30],
   //            complete[55], piece_done[56], zero fill above
   output logic [63:0]           rsp_tdata,
   // rsp_tuser: status[2:0]
   output logic [2:0]            rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [SIZE_W-1:0] piece_size_ff, piece_size_in;
   logic [SIZE_W-1:0] eff_size;
   logic              csr_write;

   logic              rsp_full_ff, rsp_full_in;
   result_type        rsp_ff, rsp_in;
   result_type        res;
   logic              res_load, slot_free;

   logic              start, shift;
   entry_type         tail;
   entry_type         chain_q [MAX_BLOCKS];

   // Configuration: a single register, word index taken from paddr[2].
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? '0 : CSR_DATA_W'(piece_size_ff);

   always_comb begin
      piece_size_in = piece_size_ff;
      if (csr_write && !csr_paddr[2]) begin
         piece_size_in = csr_pwdata[SIZE_W-1:0];
      end
   end

   // The usable size is capped at the offset range of one piece.
   assign eff_size = piece_size_ff[SIZE_W-1] ? SIZE_W'(1) << OFF_W : piece_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         piece_size_ff <= SIZE_W'(262144);
      end else begin
         piece_size_ff <= piece_size_in;
      end
   end

   // Ring of table cells: cell 0 is the head seen by the sequencer, the
   // rewritten entry re-enters at the last cell.
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      entry_type cell_in;
      if (i == MAX_BLOCKS - 1) begin : g_tail
         assign cell_in = tail;
      end else begin : g_link
         assign cell_in = chain_q[i+1];
      end
      pbrt_cell u_cell (
         .clock     (clock),
         .shift     (shift),
         .entry_in  (cell_in),
         .entry_out (chain_q[i])
      );
   end

   assign start = req_tvalid && req_tready;

   pbrt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .opcode       (opcode_type'(req_tuser)),
      .block_length (req_tdata[24:0]),
      .block_offset (req_tdata[48:25]),
      .entry_index  (req_tdata[54:49]),
      .flag_value   (req_tdata[55]),
      .eff_size     (eff_size),
      .head         (chain_q[0]),
      .head_next    (chain_q[1]),
      .slot_free    (slot_free),
      .ready        (req_tready),
      .shift        (shift),
      .tail         (tail),
      .res_load     (res_load),
      .res          (res)
   );

   // Output register: decouples the result from the next request's work.
   assign slot_free = !rsp_full_ff || rsp_tready;

   always_comb begin
      rsp_full_in = rsp_full_ff;
      rsp_in      = rsp_ff;
      if (res_load) begin
         rsp_full_in = 1'b1;
         rsp_in      = res;
      end else if (rsp_tready) begin
         rsp_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_full_ff <= 1'b0;
      end else begin
         rsp_full_ff <= rsp_full_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_full_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {7'b0, rsp_ff.piece_done, rsp_ff.complete, rsp_ff.length,
                        rsp_ff.begin_off, rsp_ff.index};

endmodule
